@@ rtl/core/ttpc_pkg.sv @@
`timescale 1ns / 1ps

package ttpc_pkg;

  localparam int NumTrips = 2;
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 32;
  localparam int InDataW  = 40;   // temperature, request index, zero fill
  localparam int OutDataW = 16;   // cap, any, granted, failure count, zero fill

  typedef enum logic [1:0] {
    FuncSample  = 2'd0,
    FuncFail    = 2'd1,
    FuncRequest = 2'd2
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTrip0Thr  = 4'd0,
    CfgTrip0Hyst = 4'd1,
    CfgTrip0Cap  = 4'd2,
    CfgTrip1Thr  = 4'd3,
    CfgTrip1Hyst = 4'd4,
    CfgTrip1Cap  = 4'd5,
    CfgFailLimit = 4'd6,
    CfgFailSafe  = 4'd7
  } cfg_idx_e;

  localparam logic [31:0] Trip0ThrRst  = 32'd85000;
  localparam logic [30:0] Trip0HystRst = 31'd5000;
  localparam logic [2:0]  Trip0CapRst  = 3'd4;
  localparam logic [31:0] Trip1ThrRst  = 32'd95000;
  localparam logic [30:0] Trip1HystRst = 31'd5000;
  localparam logic [2:0]  Trip1CapRst  = 3'd7;
  localparam logic [7:0]  FailLimitRst = 8'd3;
  localparam logic        FailSafeRst  = 1'b1;

  localparam logic [7:0]  FailCntMax   = 8'hFF;

  typedef struct packed {
    logic [NumTrips-1:0][31:0] thr;
    logic [NumTrips-1:0][30:0] hyst;
    logic [NumTrips-1:0][2:0]  cap;
    logic [7:0]                fail_limit;
    logic                      fail_safe_en;
  } cfg_t;

  // Slowest state index, limited to what a 3-bit index holds.
  function automatic logic [2:0] last_idx(int unsigned n);
    logic [2:0] r;
    if (n > 8) begin
      r = 3'd7;
    end else begin
      r = 3'(n - 1);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/ttpc_cfg_regs.sv @@
`timescale 1ns / 1ps

module ttpc_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ttpc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ttpc_pkg::CfgDataW-1:0]   cfg_data_i,
  output ttpc_pkg::cfg_t                  cfg_o
);
  import ttpc_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgTrip0Thr:  cfg_d.thr[0]       = cfg_data_i;
        CfgTrip0Hyst: cfg_d.hyst[0]      = cfg_data_i[30:0];
        CfgTrip0Cap:  cfg_d.cap[0]       = cfg_data_i[2:0];
        CfgTrip1Thr:  cfg_d.thr[1]       = cfg_data_i;
        CfgTrip1Hyst: cfg_d.hyst[1]      = cfg_data_i[30:0];
        CfgTrip1Cap:  cfg_d.cap[1]       = cfg_data_i[2:0];
        CfgFailLimit: cfg_d.fail_limit   = cfg_data_i[7:0];
        CfgFailSafe:  cfg_d.fail_safe_en = cfg_data_i[0];
        default:      cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thr[0]       <= Trip0ThrRst;
      cfg_q.hyst[0]      <= Trip0HystRst;
      cfg_q.cap[0]       <= Trip0CapRst;
      cfg_q.thr[1]       <= Trip1ThrRst;
      cfg_q.hyst[1]      <= Trip1HystRst;
      cfg_q.cap[1]       <= Trip1CapRst;
      cfg_q.fail_limit   <= FailLimitRst;
      cfg_q.fail_safe_en <= FailSafeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/ttpc_trip_eval.sv @@
`timescale 1ns / 1ps

module ttpc_trip_eval #(
  parameter int unsigned NumPstates = 8
) (
  input  logic [31:0]                   temp_i,
  input  ttpc_pkg::cfg_t                cfg_i,
  input  logic [ttpc_pkg::NumTrips-1:0] flags_i,
  output logic [ttpc_pkg::NumTrips-1:0] flags_o,
  output logic [2:0]                    cap_o,
  output logic                          any_o
);
  import ttpc_pkg::*;

  localparam logic [2:0] LastIdx = last_idx(NumPstates);

  logic signed [32:0] release_lvl [NumTrips];
  logic [2:0]         trip_cap    [NumTrips];

  // Release level is thr - hyst in 33 bits, so it cannot wrap.
  for (genvar t = 0; t < NumTrips; t++) begin : g_trip
    assign release_lvl[t] = $signed({cfg_i.thr[t][31], cfg_i.thr[t]})
                          - $signed({2'b00, cfg_i.hyst[t]});
    assign trip_cap[t]    = (cfg_i.cap[t] > LastIdx) ? LastIdx : cfg_i.cap[t];

    assign flags_o[t] = flags_i[t]
                      ? !($signed({temp_i[31], temp_i}) <= release_lvl[t])
                      : ($signed(temp_i) >= $signed(cfg_i.thr[t]));
  end

  always_comb begin
    cap_o = '0;
    for (int t = 0; t < NumTrips; t++) begin
      if (flags_o[t] && (trip_cap[t] > cap_o)) begin
        cap_o = trip_cap[t];
      end
    end
  end

  assign any_o = |flags_o;

endmodule

@@ rtl/core/thermal_trip_perf_cap_unit.sv @@
`timescale 1ns / 1ps

// Thermal trip points with hysteresis capping a performance-state index.
// Input stream (s_axis_*): tuser carries the item kind (good sample, sensor
// failure, state request); tdata carries the temperature in millidegrees and
// the requested index. Every accepted transaction yields exactly one result
// transaction on m_axis_*: current cap, cap-active flag, granted index and
// the consecutive failure count.
// Configuration: cfg_valid_i/cfg_ready_o write channel, register index plus
// 32-bit data; ready is always high. Write only while the block is idle.
// Pipeline: a transaction passes through the input register, then the
// trip/counter logic into the result register, which drives m_axis_tvalid.
// Throughput is one transaction per cycle while the receiver does not
// stall; the trip flags and the failure counter update as the
// transaction moves into the result register.
// When the receiver stalls, the result register holds and the input register
// holds one more transaction; tready drops only when both are full.
// Reset clears the trip flags, held cap, failure count and both pipeline
// valid bits, and loads the configuration registers with their defaults.
module thermal_trip_perf_cap_unit #(
  parameter int unsigned NUM_PSTATES = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] temp_mdeg, [34:32] req_idx, [39:35] zero
  input  logic [ttpc_pkg::InDataW-1:0]  s_axis_tdata,
  // [1:0] func
  input  logic [1:0]                    s_axis_tuser,
  // master stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [2:0] cap_idx, [3] any_trip_active, [6:4] granted_index,
  // [14:7] failure_count, [15] zero
  output logic [ttpc_pkg::OutDataW-1:0] m_axis_tdata,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ttpc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ttpc_pkg::CfgDataW-1:0] cfg_data_i
);
  import ttpc_pkg::*;

  localparam logic [2:0] LastIdx = last_idx(NUM_PSTATES);

  cfg_t cfg;

  // input register
  logic        in_valid_q;
  logic [1:0]  in_func_q;
  logic [31:0] in_temp_q;
  logic [2:0]  in_req_q;

  // block state
  logic [NumTrips-1:0] flags_q, flags_d;
  logic [2:0]          cap_q, cap_d;
  logic                active_q, active_d;
  logic [7:0]          fcnt_q, fcnt_d;

  // result register
  logic        out_valid_q;
  logic [2:0]  granted_d;
  logic [OutDataW-1:0] out_data_q;

  logic                adv, step;
  logic [NumTrips-1:0] eval_flags;
  logic [2:0]          eval_cap;
  logic                eval_any;
  logic [7:0]          fcnt_inc;

  ttpc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ttpc_trip_eval #(
    .NumPstates (NUM_PSTATES)
  ) u_eval (
    .temp_i  (in_temp_q),
    .cfg_i   (cfg),
    .flags_i (flags_q),
    .flags_o (eval_flags),
    .cap_o   (eval_cap),
    .any_o   (eval_any)
  );

  assign adv           = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && adv;
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func_q <= s_axis_tuser;
      in_temp_q <= s_axis_tdata[31:0];
      in_req_q  <= s_axis_tdata[34:32];
    end
  end

  assign fcnt_inc = (fcnt_q == FailCntMax) ? fcnt_q : fcnt_q + 8'd1;

  always_comb begin
    flags_d  = flags_q;
    cap_d    = cap_q;
    active_d = active_q;
    fcnt_d   = fcnt_q;
    unique case (func_e'(in_func_q))
      FuncSample: begin
        fcnt_d   = '0;
        flags_d  = eval_flags;
        cap_d    = eval_cap;
        active_d = eval_any;
      end
      FuncFail: begin
        fcnt_d = fcnt_inc;
        // fail-safe leaves the trip flags alone
        if (cfg.fail_safe_en && (fcnt_inc >= cfg.fail_limit)) begin
          cap_d    = LastIdx;
          active_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    granted_d = cap_d;
    if (func_e'(in_func_q) == FuncRequest) begin
      if (32'(in_req_q) >= 32'(NUM_PSTATES)) begin
        granted_d = in_req_q;
      end else begin
        granted_d = (in_req_q > cap_d) ? in_req_q : cap_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      cap_q       <= '0;
      active_q    <= 1'b0;
      fcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        flags_q  <= flags_d;
        cap_q    <= cap_d;
        active_q <= active_d;
        fcnt_q   <= fcnt_d;
      end
      if (adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= {1'b0, fcnt_d, granted_d, active_d, cap_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_sample_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && (in_func_q == FuncSample)) |=> (fcnt_q == '0))
    else $error("failure count not cleared by good sample");

  a_idle_cap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (cap_q == '0))
    else $error("cap held without an active trip or fail-safe");

  a_fail_count_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && (in_func_q == FuncFail)) |=> (fcnt_q != '0))
    else $error("failure count did not advance or saturate");

  a_grant_not_below_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q[6:4] >= out_data_q[2:0]))
    else $error("granted index below cap");

  a_state_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> ($stable(cap_q) && $stable(fcnt_q) && $stable(flags_q)))
    else $error("state changed without a transaction");

endmodule
